>>> hw/rtl/mmdp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmdp_pkg
// Shared types and constants of the min/max decimation pyramid.
// ----------------------------------------------------------------------------
package mmdp_pkg;
	localparam int LEVEL_W = 5;
	localparam int INDEX_W = 23;
	localparam int CFG_W   = 16;

	localparam logic [0:0] REG_CHANNEL_COUNT = 1'd0;
	localparam logic [0:0] REG_BUCKET_FRAMES = 1'd1;

	localparam logic CMD_PUSH   = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_CLEAR
	} state_t;

	// token moving along the chain of level cells
	typedef struct packed {
		logic valid;
		logic fin;
		logic have;
		logic stop;
	} token_t;
endpackage
`default_nettype wire

>>> hw/rtl/mmdp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmdp_in_if / mmdp_out_if
// Valid/ready channels of the pyramid.
// ----------------------------------------------------------------------------
interface mmdp_in_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic                          command;
	logic signed [SAMPLE_BITS-1:0] sample;
	modport source (output valid, command, sample, input ready);
	modport sink (input valid, command, sample, output ready);
endinterface

interface mmdp_out_if #(parameter int SAMPLE_BITS = 16);
	logic                            valid;
	logic                            ready;
	logic [mmdp_pkg::LEVEL_W-1:0]    level;
	logic [mmdp_pkg::INDEX_W-1:0]    bucket_index;
	logic signed [SAMPLE_BITS-1:0]   min_value;
	logic signed [SAMPLE_BITS-1:0]   max_value;
	logic                            last;
	modport source (output valid, level, bucket_index, min_value, max_value, last,
		input ready);
	modport sink (input valid, level, bucket_index, min_value, max_value, last,
		output ready);
endinterface
`default_nettype wire

>>> hw/rtl/mmdp_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmdp_cell
// One pyramid level: holds the unpaired bucket and the emit count, emits
// the arriving bucket and hands the merged pair to the next level.
// ----------------------------------------------------------------------------
module mmdp_cell #(
	parameter int SAMPLE_BITS = 16,
	parameter logic TOP = 1'b0
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            clear,
	input  mmdp_pkg::token_t               tok_in,
	input  wire signed [SAMPLE_BITS-1:0]   lo_in,
	input  wire signed [SAMPLE_BITS-1:0]   hi_in,
	input  wire                            emit_busy,
	output mmdp_pkg::token_t               tok_out,
	output logic signed [SAMPLE_BITS-1:0]  lo_out,
	output logic signed [SAMPLE_BITS-1:0]  hi_out,
	output logic                           emit,
	output logic [mmdp_pkg::INDEX_W-1:0]   emit_index
);
	localparam int INDEX_W = mmdp_pkg::INDEX_W;

	logic                           pend_q;
	logic signed [SAMPLE_BITS-1:0]  plo_q;
	logic signed [SAMPLE_BITS-1:0]  phi_q;
	logic [mmdp_pkg::INDEX_W-1:0]   cnt_q;
	logic signed [SAMPLE_BITS-1:0]  mlo;
	logic signed [SAMPLE_BITS-1:0]  mhi;
	logic                           act;

	assign act = tok_in.valid && !emit_busy;
	assign mlo = (plo_q < lo_in) ? plo_q : lo_in;
	assign mhi = (phi_q > hi_in) ? phi_q : hi_in;

	always_comb begin
		tok_out    = '0;
		lo_out     = lo_in;
		hi_out     = hi_in;
		emit       = 1'b0;
		emit_index = cnt_q;
		if (act) begin
			if (!tok_in.fin) begin
				emit = 1'b1;
				if (!TOP && pend_q) begin
					tok_out = '{valid: 1'b1, fin: 1'b0, have: 1'b1, stop: 1'b0};
					lo_out  = mlo;
					hi_out  = mhi;
				end
			end else if (!tok_in.stop) begin
				// finish: emit incoming bucket if present, then carry upward
				emit = tok_in.have;
				if (!TOP) begin
					tok_out.valid = 1'b1;
					tok_out.fin   = 1'b1;
					tok_out.stop  = (cnt_q + INDEX_W'(tok_in.have)) <= INDEX_W'(1);
					tok_out.have  = tok_in.have || pend_q;
					if (tok_in.have && pend_q) begin
						lo_out = mlo;
						hi_out = mhi;
					end else if (pend_q) begin
						lo_out = plo_q;
						hi_out = phi_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			cnt_q  <= '0;
		end else if (clear) begin
			pend_q <= 1'b0;
			cnt_q  <= '0;
		end else if (act && !tok_in.fin) begin
			cnt_q <= cnt_q + INDEX_W'(1);
			if (!TOP) pend_q <= !pend_q;
		end else if (act && !tok_in.stop && tok_in.have) begin
			cnt_q <= cnt_q + INDEX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (act && !tok_in.fin && !pend_q) begin
			plo_q <= lo_in;
			phi_q <= hi_in;
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/minmax_decimation_pyramid.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// minmax_decimation_pyramid
// Folds interleaved samples into min/max buckets and cascades them through
// a chain of level cells, one result beat per cell.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_ch   | in  | command, sample
//  out_ch  | out | level, bucket_index, min_value, max_value, last
//  cfg     | in  | cfg_we, cfg_index, cfg_data
// A push beat that fills a bucket sends a token up the chain, one result per
// level it reaches. A finish beat carries up through each level the carry
// reaches and a stop token below the top, then leaves the chain and clears
// the state. The input is not ready again until the chain is empty.
// An output stall freezes the chain. Reset clears control state.
// ----------------------------------------------------------------------------
module minmax_decimation_pyramid #(
	parameter int LEVELS       = 24,
	parameter int SAMPLE_BITS  = 16,
	parameter int MAX_CHANNELS = 8
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire [0:0]                   cfg_index,
	input  wire [mmdp_pkg::CFG_W-1:0]   cfg_data,
	mmdp_in_if.sink                     in_ch,
	mmdp_out_if.source                  out_ch
);
	localparam int LEVEL_W = mmdp_pkg::LEVEL_W;
	localparam int INDEX_W = mmdp_pkg::INDEX_W;

	logic [3:0]                      chan_q;
	logic [15:0]                     bf_q;
	mmdp_pkg::state_t                state_q, state_d;
	logic                            fin_q;
	logic signed [SAMPLE_BITS-1:0]   flo_q, fhi_q, blo_q, bhi_q;
	logic [3:0]                      pos_q;
	logic [15:0]                     fib_q;

	mmdp_pkg::token_t                tok [LEVELS+1];
	logic signed [SAMPLE_BITS-1:0]   tlo [LEVELS+1];
	logic signed [SAMPLE_BITS-1:0]   thi [LEVELS+1];
	mmdp_pkg::token_t                tok_q [LEVELS];
	logic signed [SAMPLE_BITS-1:0]   tlo_q [LEVELS];
	logic signed [SAMPLE_BITS-1:0]   thi_q [LEVELS];
	logic [LEVELS-1:0]               emit;
	logic [INDEX_W-1:0]              eidx [LEVELS];
	logic                            busy, ov_q, clear, accept, any_tok;
	logic [LEVEL_W-1:0]              ol_q;
	logic [INDEX_W-1:0]              oi_q;
	logic signed [SAMPLE_BITS-1:0]   olo_q, ohi_q;
	logic                            olast_q;
	logic [3:0]                      ch_eff;
	logic [15:0]                     bf_eff, fib_nx;
	logic signed [SAMPLE_BITS-1:0]   nflo, nfhi, nblo, nbhi;
	logic                            fdone, bfull;
	logic [LEVELS-1:0]               tv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= 4'd1;
			bf_q   <= 16'd256;
		end else if (cfg_we) begin
			if (cfg_index == mmdp_pkg::REG_CHANNEL_COUNT) chan_q <= cfg_data[3:0];
			else bf_q <= cfg_data;
		end
	end

	assign ch_eff = (chan_q == 4'd0) ? 4'd1 :
		(32'(chan_q) > MAX_CHANNELS) ? 4'(MAX_CHANNELS) : chan_q;
	assign bf_eff = (bf_q == 16'd0) ? 16'd1 : bf_q;

	assign busy   = ov_q && !out_ch.ready;
	always_comb begin
		for (int k = 0; k < LEVELS; k++) tv[k] = tok_q[k].valid;
	end
	assign any_tok = |tv;
	assign in_ch.ready = (state_q == mmdp_pkg::ST_IDLE);
	assign accept = in_ch.valid && in_ch.ready;
	assign clear  = (state_q == mmdp_pkg::ST_CLEAR);

	always_comb begin
		nflo = in_ch.sample;
		nfhi = in_ch.sample;
		if (pos_q != 4'd0) begin
			if (flo_q < in_ch.sample) nflo = flo_q;
			if (fhi_q > in_ch.sample) nfhi = fhi_q;
		end
		fdone = (pos_q + 4'd1) >= ch_eff;
		nblo  = nflo;
		nbhi  = nfhi;
		if (fib_q != 16'd0) begin
			if (blo_q < nflo) nblo = blo_q;
			if (bhi_q > nfhi) nbhi = bhi_q;
		end
		fib_nx = fib_q + 16'd1;
		bfull  = (fib_nx >= bf_eff) || (fib_nx == 16'd0);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mmdp_pkg::ST_IDLE: if (accept) state_d = mmdp_pkg::ST_RUN;
			mmdp_pkg::ST_RUN:
				if (!any_tok && !busy) state_d = fin_q ? mmdp_pkg::ST_CLEAR
					: mmdp_pkg::ST_IDLE;
			default: state_d = mmdp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmdp_pkg::ST_IDLE;
			fin_q   <= 1'b0;
			pos_q   <= '0;
			fib_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) fin_q <= (in_ch.command == mmdp_pkg::CMD_FINISH);
			if (clear) begin
				pos_q <= '0;
				fib_q <= '0;
			end else if (accept && in_ch.command == mmdp_pkg::CMD_PUSH) begin
				if (fdone) begin
					pos_q <= '0;
					fib_q <= bfull ? 16'd0 : fib_nx;
				end else begin
					pos_q <= pos_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_ch.command == mmdp_pkg::CMD_PUSH) begin
			flo_q <= nflo;
			fhi_q <= nfhi;
			if (fdone) begin
				blo_q <= nblo;
				bhi_q <= nbhi;
			end
		end
	end

	// chain input: token into level 0
	always_comb begin
		tok[0] = '0;
		tlo[0] = nblo;
		thi[0] = nbhi;
		if (accept && in_ch.command == mmdp_pkg::CMD_PUSH && fdone && bfull)
			tok[0].valid = 1'b1;
		if (accept && in_ch.command == mmdp_pkg::CMD_FINISH) begin
			tok[0] = '{valid: 1'b1, fin: 1'b1, have: (fib_q != 16'd0), stop: 1'b0};
			tlo[0] = blo_q;
			thi[0] = bhi_q;
		end
	end

	for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
		mmdp_pkg::token_t tin;
		assign tin = (k == 0) ? tok[0] : tok_q[k];
		mmdp_cell #(.SAMPLE_BITS(SAMPLE_BITS), .TOP(k == LEVELS - 1)) u_cell (
			.clk(clk), .arst_n(arst_n), .clear(clear),
			.tok_in(tin),
			.lo_in((k == 0) ? tlo[0] : tlo_q[k]),
			.hi_in((k == 0) ? thi[0] : thi_q[k]),
			.emit_busy(busy),
			.tok_out(tok[k+1]), .lo_out(tlo[k+1]), .hi_out(thi[k+1]),
			.emit(emit[k]), .emit_index(eidx[k])
		);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) tok_q[k] <= '0;
			else if (k > 0 && !busy) tok_q[k] <= tok[k];
			else if (k == 0) tok_q[k] <= '0;
		end
		always_ff @(posedge clk) begin
			if (!busy) begin
				tlo_q[k] <= tlo[k];
				thi_q[k] <= thi[k];
			end
		end
	end

	// output register; level 0 cell sees input only when not stalled
	logic [LEVEL_W-1:0]            sel_l;
	logic [INDEX_W-1:0]            sel_i;
	logic signed [SAMPLE_BITS-1:0] sel_lo, sel_hi;
	logic                          sel_v, sel_last;
	always_comb begin
		sel_v  = 1'b0;
		sel_l  = '0;
		sel_i  = '0;
		sel_lo = '0;
		sel_hi = '0;
		sel_last = 1'b0;
		for (int k = 0; k < LEVELS; k++) begin
			if (emit[k]) begin
				sel_v  = 1'b1;
				sel_l  = LEVEL_W'(k);
				sel_i  = eidx[k];
				sel_lo = (k == 0) ? tlo[0] : tlo_q[k];
				sel_hi = (k == 0) ? thi[0] : thi_q[k];
				sel_last = !tok[k+1].valid ||
					(tok[k+1].fin && (tok[k+1].stop || !tok[k+1].have));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (!busy) ov_q <= sel_v;
	end

	always_ff @(posedge clk) begin
		if (!busy) begin
			ol_q <= sel_l;
			oi_q <= sel_i;
			olo_q <= sel_lo;
			ohi_q <= sel_hi;
			olast_q <= sel_last;
		end
	end

	assign out_ch.valid        = ov_q;
	assign out_ch.level        = ol_q;
	assign out_ch.bucket_index = oi_q;
	assign out_ch.min_value    = olo_q;
	assign out_ch.max_value    = ohi_q;
	assign out_ch.last         = olast_q;
endmodule
`default_nettype wire
